// File: design/wtra_pkg.sv
// wtra_pkg: shared types and constants of the transmit rate adaptation block
// station table entry layout, command and rate-change codes, register indexes
// no dependencies
`default_nettype none

package wtra_pkg;

  localparam int STA_W     = 4;
  localparam int RATE_W    = 4;
  localparam int CNT_W     = 5;
  localparam int THR_W     = 8;
  localparam int CTR_W     = 16;
  localparam int FRM_W     = 8;
  localparam int CMD_W     = 2;
  localparam int CHG_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_RATES = 16;

  localparam logic [THR_W-1:0] MIN_THR_RST = 8'd1;
  localparam logic [THR_W-1:0] MAX_THR_RST = 8'd15;
  localparam logic [CTR_W-1:0] ENOUGH_TX   = 16'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CHOOSE = 2'd2
  } cmd_t;

  typedef enum logic [CHG_W-1:0] {
    CHG_NONE = 2'd0,
    CHG_UP   = 2'd1,
    CHG_DOWN = 2'd2
  } chg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_THR = 2'd0,
    CFG_MAX_THR = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [CTR_W-1:0]  tx_total;
    logic [CTR_W-1:0]  retry_total;
    logic [THR_W-1:0]  good_run;
    logic [THR_W-1:0]  success_threshold;
    logic              recovering;
    logic [RATE_W-1:0] current_rate;
    logic [CNT_W-1:0]  rate_limit;
  } entry_t;

endpackage

`default_nettype wire

// File: design/wtra_if.sv
// wtra_if: valid/ready channels of the rate adaptation block
// request channel, result channel and register write channel
// depends on wtra_pkg for field widths
`default_nettype none

interface wtra_in_if;
  logic                        valid;
  logic                        ready;
  logic [wtra_pkg::CMD_W-1:0]  command;
  logic [wtra_pkg::STA_W-1:0]  station;
  logic [wtra_pkg::FRM_W-1:0]  frames_sent;
  logic [wtra_pkg::FRM_W-1:0]  retries_seen;
  logic [wtra_pkg::CNT_W-1:0]  rate_count;
  logic [wtra_pkg::RATE_W-1:0] start_rate;

  modport source (output valid, command, station, frames_sent, retries_seen, rate_count,
                  start_rate, input ready);
  modport sink (input valid, command, station, frames_sent, retries_seen, rate_count,
                start_rate, output ready);
endinterface

interface wtra_out_if;
  logic                        valid;
  logic                        ready;
  logic [wtra_pkg::STA_W-1:0]  station_out;
  logic [wtra_pkg::RATE_W-1:0] rate_index;
  logic [wtra_pkg::CHG_W-1:0]  rate_change;
  logic [wtra_pkg::THR_W-1:0]  threshold_now;

  modport source (output valid, station_out, rate_index, rate_change, threshold_now,
                  input ready);
  modport sink (input valid, station_out, rate_index, rate_change, threshold_now,
                output ready);
endinterface

interface wtra_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wtra_pkg::CFG_IDX_W-1:0] index;
  logic [wtra_pkg::THR_W-1:0]     wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// File: design/wireless_tx_rate_adaptation_core.sv
// wireless_tx_rate_adaptation_core: per-station transmit rate selector
// station table in one synchronous memory, read-modify-write with forwarding
// depends on wtra_pkg and the channels in wtra_if
//
// usage
//   in_ch carries one request: init (load a station), report (add frame and
//   retry counts, saturating at 16 bits) or choose (apply the step-up /
//   step-down rule). every request gives exactly one result on out_ch.
//   cfg_ch writes the minimum and maximum success threshold; write it only
//   while no request is in flight. cfg_ch.ready is always high.
//   a request goes through the read stage into the result register, which
//   drives out_ch. throughput: one request per cycle while out_ch is not
//   stalled. the table memory is read in the cycle of acceptance and written
//   back when the request leaves the read stage; a request to the station
//   that is being written takes the new entry through a forwarding register.
//   the result register parts the two sides: while out_ch is stalled one
//   more request is taken into the read stage, after that in_ch.ready drops.
//   reset clears the control state and sets the thresholds to 1 and 15; the
//   table is not cleared, so the user must init each station first (not enforced).
`default_nettype none

module wireless_tx_rate_adaptation_core #(
  parameter int NUM_STATIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  wtra_in_if.sink   in_ch,
  wtra_out_if.source out_ch,
  wtra_cfg_if.sink  cfg_ch
);
  import wtra_pkg::*;

  localparam int AW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

  logic [THR_W-1:0] min_thr_r;
  logic [THR_W-1:0] max_thr_r;

  logic acc;
  logic advance;
  logic we;

  logic [AW+STA_W-1:0] sta_ext;
  logic [AW-1:0]       rd_addr;
  logic                rd_hit;

  entry_t mem_r [NUM_STATIONS];
  entry_t rd_r;
  entry_t fwd_data_r;
  logic   fwd_r;

  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [STA_W-1:0]  s1_sta_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_hit_r;
  logic [FRM_W-1:0]  s1_frm_r;
  logic [FRM_W-1:0]  s1_rty_r;
  logic [CNT_W-1:0]  s1_cnt_r;
  logic [RATE_W-1:0] s1_sr_r;

  logic              out_valid_r;
  logic [STA_W-1:0]  out_sta_r;
  logic [RATE_W-1:0] out_rate_r;
  chg_t              out_chg_r;
  logic [THR_W-1:0]  out_thr_r;

  entry_t            cur;
  entry_t            wdata;
  logic              upd;
  chg_t              chg;
  logic [RATE_W-1:0] res_rate;
  logic [THR_W-1:0]  res_thr;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_thr_r <= MIN_THR_RST;
      max_thr_r <= MAX_THR_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_MIN_THR: min_thr_r <= cfg_ch.wdata;
        CFG_MAX_THR: max_thr_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // handshakes
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign acc         = in_ch.valid && in_ch.ready;
  assign we          = s1_valid_r && advance && s1_hit_r && upd;

  assign sta_ext = {{AW{1'b0}}, in_ch.station};
  assign rd_addr = sta_ext[AW-1:0];
  assign rd_hit  = int'(in_ch.station) < NUM_STATIONS;

  // station table
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[s1_addr_r] <= wdata;
    end
    if (acc) begin
      rd_r       <= mem_r[rd_addr];
      fwd_r      <= we && (s1_addr_r == rd_addr);
      fwd_data_r <= wdata;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r  <= in_ch.command;
      s1_sta_r  <= in_ch.station;
      s1_addr_r <= rd_addr;
      s1_hit_r  <= rd_hit;
      s1_frm_r  <= in_ch.frames_sent;
      s1_rty_r  <= in_ch.retries_seen;
      s1_cnt_r  <= in_ch.rate_count;
      s1_sr_r   <= in_ch.start_rate;
    end
  end

  // entry update
  always_comb begin
    logic [CTR_W:0]    tx_sum;
    logic [CTR_W:0]    rt_sum;
    logic [CTR_W:0]    rt_inc;
    logic [CTR_W+4:0]  ten_rt;
    logic [CTR_W+1:0]  three_rt;
    logic              enough;
    logic              success;
    logic              failure;
    logic              at_max;
    logic [THR_W-1:0]  run_inc;
    logic [THR_W:0]    dbl;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  cnt_m1;

    cur    = fwd_r ? fwd_data_r : rd_r;
    wdata  = cur;
    upd    = 1'b0;
    chg    = CHG_NONE;

    tx_sum   = {1'b0, cur.tx_total} + {{(CTR_W-FRM_W+1){1'b0}}, s1_frm_r};
    rt_sum   = {1'b0, cur.retry_total} + {{(CTR_W-FRM_W+1){1'b0}}, s1_rty_r};
    rt_inc   = {1'b0, cur.retry_total} + {{CTR_W{1'b0}}, 1'b1};
    ten_rt   = ({4'b0, rt_inc} << 3) + ({4'b0, rt_inc} << 1);
    three_rt = {1'b0, cur.retry_total, 1'b0} + {2'b0, cur.retry_total};
    enough   = cur.tx_total > ENOUGH_TX;
    success  = {5'b0, cur.tx_total} >= ten_rt;
    failure  = three_rt > {2'b0, cur.tx_total};
    at_max   = ({1'b0, cur.current_rate} + {{RATE_W{1'b0}}, 1'b1}) == cur.rate_limit;
    run_inc  = (cur.good_run == {THR_W{1'b1}}) ? cur.good_run : cur.good_run + 1'b1;
    dbl      = {cur.success_threshold, 1'b0};

    cnt = s1_cnt_r;
    if (cnt == '0) begin
      cnt = CNT_W'(1);
    end else if (cnt > CNT_W'(MAX_RATES)) begin
      cnt = CNT_W'(MAX_RATES);
    end
    cnt_m1 = cnt - 1'b1;

    unique case (cmd_t'(s1_cmd_r))
      CMD_INIT: begin
        upd                     = 1'b1;
        wdata.tx_total          = '0;
        wdata.retry_total       = '0;
        wdata.good_run          = '0;
        wdata.recovering        = 1'b0;
        wdata.success_threshold = min_thr_r;
        wdata.rate_limit        = cnt;
        wdata.current_rate      = ({1'b0, s1_sr_r} > cnt_m1) ? cnt_m1[RATE_W-1:0] : s1_sr_r;
      end
      CMD_REPORT: begin
        upd               = 1'b1;
        wdata.tx_total    = tx_sum[CTR_W] ? {CTR_W{1'b1}} : tx_sum[CTR_W-1:0];
        wdata.retry_total = rt_sum[CTR_W] ? {CTR_W{1'b1}} : rt_sum[CTR_W-1:0];
      end
      CMD_CHOOSE: begin
        upd = 1'b1;
        priority if (success && enough) begin
          if (run_inc >= cur.success_threshold && !at_max) begin
            wdata.recovering   = 1'b1;
            wdata.good_run     = '0;
            wdata.current_rate = cur.current_rate + 1'b1;
            chg                = CHG_UP;
          end else begin
            wdata.recovering = 1'b0;
            wdata.good_run   = run_inc;
          end
        end else if (failure) begin
          wdata.good_run = '0;
          if (cur.current_rate != '0) begin
            if (cur.recovering) begin
              wdata.success_threshold = (dbl > {1'b0, max_thr_r}) ? max_thr_r : dbl[THR_W-1:0];
            end else begin
              wdata.success_threshold = min_thr_r;
            end
            wdata.current_rate = cur.current_rate - 1'b1;
            chg                = CHG_DOWN;
          end
          wdata.recovering = 1'b0;
        end else begin
        end
        if (enough || chg != CHG_NONE) begin
          wdata.tx_total    = '0;
          wdata.retry_total = '0;
        end
      end
      default: ;
    endcase

    if (s1_hit_r) begin
      res_rate = wdata.current_rate;
      res_thr  = wdata.success_threshold;
    end else begin
      res_rate = '0;
      res_thr  = '0;
      chg      = CHG_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_sta_r  <= s1_sta_r;
      out_rate_r <= res_rate;
      out_chg_r  <= chg;
      out_thr_r  <= res_thr;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.station_out   = out_sta_r;
  assign out_ch.rate_index    = out_rate_r;
  assign out_ch.rate_change   = out_chg_r;
  assign out_ch.threshold_now = out_thr_r;

  // checks
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r)
    else $error("request channel stalled with a free stage");

  a_forward_taken: assert property (@(posedge clk) disable iff (!rst_n)
    acc && we && (s1_addr_r == rd_addr) |=> fwd_r)
    else $error("write-back to the station being read not forwarded");

  a_step_up_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chg_r == CHG_UP |-> out_rate_r != '0)
    else $error("rate increase reported with rate index zero");

  a_step_down_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chg_r == CHG_DOWN |->
      (out_thr_r <= max_thr_r) || (out_thr_r == min_thr_r))
    else $error("threshold after a drop above its ceiling");

endmodule

`default_nettype wire

// File: tb/wtra_checker.sv
`timescale 1ns / 100ps
// wtra_checker: keeps its own copy of the station table and thresholds, predicts the result
// of every accepted request and compares it with the result channel
// depends on wtra_pkg and the channels in wtra_if
module wtra_checker (
  input  logic clk,
  input  logic rst_n,
  wtra_in_if   in_ch,
  wtra_out_if  out_ch,
  wtra_cfg_if  cfg_ch,
  output int   fail_count,
  output int   due_count
);
  import wtra_pkg::*;

  typedef struct packed {
    logic [STA_W-1:0]  station;
    logic [RATE_W-1:0] rate;
    chg_t              change;
    logic [THR_W-1:0]  threshold;
  } rate_report_t;

  entry_t           sta_table [1 << STA_W];
  logic [THR_W-1:0] min_thr;
  logic [THR_W-1:0] max_thr;
  rate_report_t     reports_due [$];
  rate_report_t     want;
  int               mismatches = 0;

  function automatic rate_report_t advance_station(
    input logic [CMD_W-1:0]  cmd,
    input logic [STA_W-1:0]  sta,
    input logic [FRM_W-1:0]  frames,
    input logic [FRM_W-1:0]  retries,
    input logic [CNT_W-1:0]  cnt,
    input logic [RATE_W-1:0] start
  );
    entry_t       e;
    rate_report_t r;
    int           limit;
    int           first;
    int           tx;
    int           rt;
    int           thr;
    logic         enough;
    logic         good;
    logic         bad;
    logic         at_top;
    e = sta_table[sta];
    r.change = CHG_NONE;
    case (cmd)
      CMD_INIT: begin
        limit = (cnt < 1) ? 1 : (cnt > MAX_RATES) ? MAX_RATES : int'(cnt);
        first = (int'(start) > limit - 1) ? limit - 1 : int'(start);
        e = '0;
        e.success_threshold = min_thr;
        e.current_rate = RATE_W'(first);
        e.rate_limit = CNT_W'(limit);
      end
      CMD_REPORT: begin
        tx = int'(e.tx_total) + int'(frames);
        rt = int'(e.retry_total) + int'(retries);
        e.tx_total = (tx > 65535) ? 16'hffff : CTR_W'(tx);
        e.retry_total = (rt > 65535) ? 16'hffff : CTR_W'(rt);
      end
      CMD_CHOOSE: begin
        tx = int'(e.tx_total);
        rt = int'(e.retry_total);
        enough = tx > int'(ENOUGH_TX);
        good = rt < tx / 10;
        bad = rt > tx / 3;
        at_top = (int'(e.current_rate) + 1) == int'(e.rate_limit);
        if (good && enough) begin
          if (e.good_run != 8'hff) e.good_run++;
          if (e.good_run >= e.success_threshold && !at_top) begin
            e.recovering = 1'b1;
            e.good_run = '0;
            e.current_rate++;
            r.change = CHG_UP;
          end else begin
            e.recovering = 1'b0;
          end
        end else if (bad) begin
          e.good_run = '0;
          if (e.current_rate != 0) begin
            if (e.recovering) begin
              thr = int'(e.success_threshold) * 2;
              if (thr > int'(max_thr)) thr = int'(max_thr);
              e.success_threshold = THR_W'(thr);
            end else begin
              e.success_threshold = min_thr;
            end
            e.current_rate--;
            r.change = CHG_DOWN;
          end
          e.recovering = 1'b0;
        end
        if (enough || r.change != CHG_NONE) begin
          e.tx_total = '0;
          e.retry_total = '0;
        end
      end
      default: ;
    endcase
    sta_table[sta] = e;
    r.station = sta;
    r.rate = e.current_rate;
    r.threshold = e.success_threshold;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      min_thr = MIN_THR_RST;
      max_thr = MAX_THR_RST;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reports_due.size() == 0) begin
          $error("result for station %0d with no request outstanding", out_ch.station_out);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (out_ch.station_out !== want.station) begin
            $error("station_out: expected %0d, got %0d", want.station, out_ch.station_out);
            mismatches++;
          end
          if (out_ch.rate_index !== want.rate) begin
            $error("rate_index: expected %0d, got %0d", want.rate, out_ch.rate_index);
            mismatches++;
          end
          if (out_ch.rate_change !== want.change) begin
            $error("rate_change: expected %0d, got %0d", want.change, out_ch.rate_change);
            mismatches++;
          end
          if (out_ch.threshold_now !== want.threshold) begin
            $error("threshold_now: expected %0d, got %0d", want.threshold,
                   out_ch.threshold_now);
            mismatches++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_MIN_THR) min_thr = cfg_ch.wdata;
        else if (cfg_ch.index == CFG_MAX_THR) max_thr = cfg_ch.wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        reports_due.push_back(advance_station(in_ch.command, in_ch.station, in_ch.frames_sent,
                                              in_ch.retries_seen, in_ch.rate_count,
                                              in_ch.start_rate));
      end
    end
    fail_count <= mismatches;
    due_count <= reports_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: drives requests, threshold writes and result back-pressure into the rate
// adaptation block and gives the verdict; depends on wtra_pkg, wtra_if and wtra_checker
module testbench;
  import wtra_pkg::*;

  localparam int               NUM_STA    = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic res_ready = 1'b0;
  int   res_hold = 0;
  int   res_quiet = 0;
  int   res_pick;
  int   gap_next = 0;
  int   calm_left = 0;
  int   fails;
  int   due;
  bit   sta_ready [NUM_STA];

  wtra_in_if  in_ch ();
  wtra_out_if out_ch ();
  wtra_cfg_if cfg_ch ();

  assign out_ch.ready = res_ready;

  wireless_tx_rate_adaptation_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wtra_checker rate_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fails),
    .due_count  (due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure, with stall-free stretches now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      res_hold <= 0;
      res_quiet <= 0;
    end else if (!res_ready) begin
      if (res_hold > 0) res_hold <= res_hold - 1;
      else res_ready <= 1'b1;
    end else if (out_ch.valid) begin
      if (res_quiet > 0) begin
        res_quiet <= res_quiet - 1;
      end else if ($urandom_range(0, 29) == 0) begin
        res_quiet <= $urandom_range(10, 50);
      end else begin
        res_pick = $urandom_range(0, 16);
        if (res_pick != 0) begin
          res_ready <= 1'b0;
          res_hold <= res_pick - 1;
        end
      end
    end
  end

  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [STA_W-1:0] sta,
                          input logic [FRM_W-1:0] frames, input logic [FRM_W-1:0] retries,
                          input logic [CNT_W-1:0] cnt, input logic [RATE_W-1:0] start);
    if (gap_next > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_next) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.station <= sta;
    in_ch.frames_sent <= frames;
    in_ch.retries_seen <= retries;
    in_ch.rate_count <= cnt;
    in_ch.start_rate <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (calm_left > 0) begin
      calm_left--;
      gap_next = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 40);
      gap_next = 0;
    end else begin
      gap_next = $urandom_range(0, 16);
    end
  endtask

  task automatic init_sta(input logic [STA_W-1:0] sta, input logic [CNT_W-1:0] cnt,
                          input logic [RATE_W-1:0] start);
    send_req(CMD_INIT, sta, FRM_W'($urandom), FRM_W'($urandom), cnt, start);
    sta_ready[sta] = 1'b1;
  endtask

  task automatic report_tx(input logic [STA_W-1:0] sta, input logic [FRM_W-1:0] frames,
                           input logic [FRM_W-1:0] retries);
    send_req(CMD_REPORT, sta, frames, retries, CNT_W'($urandom), RATE_W'($urandom));
  endtask

  task automatic choose_rate(input logic [STA_W-1:0] sta);
    send_req(CMD_CHOOSE, sta, FRM_W'($urandom), FRM_W'($urandom), CNT_W'($urandom),
             RATE_W'($urandom));
  endtask

  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
    drain_requests();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_MIN_THR;
    cfg_ch.wdata <= lo;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_MAX_THR;
    cfg_ch.wdata <= hi;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly report periods closed by a choose, plus re-inits and stray requests
  task automatic traffic(input int n);
    int done;
    int sta;
    int r;
    int kind;
    int reps;
    int fr;
    int rt;
    done = 0;
    while (done < n) begin
      sta = $urandom_range(0, NUM_STA - 1);
      r = $urandom_range(0, 99);
      if (!sta_ready[sta] || (r >= 70 && r < 78)) begin
        init_sta(STA_W'(sta), CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                                 : $urandom_range(1, MAX_RATES)),
                 RATE_W'($urandom_range(0, 15)));
        done++;
      end else if (r < 70) begin
        kind = $urandom_range(0, 9);
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          if (kind < 6) begin
            fr = $urandom_range(4, 255);
            rt = $urandom_range(0, fr / 15);
          end else if (kind < 9) begin
            fr = $urandom_range(1, 255);
            rt = $urandom_range(fr / 2, 255);
          end else begin
            fr = $urandom_range(0, 255);
            rt = $urandom_range(0, 255);
          end
          report_tx(STA_W'(sta), FRM_W'(fr), FRM_W'(rt));
        end
        choose_rate(STA_W'(sta));
        done += reps + 1;
      end else if (r < 84) begin
        send_req(CMD_UNUSED, STA_W'(sta), FRM_W'($urandom), FRM_W'($urandom),
                 CNT_W'($urandom), RATE_W'($urandom));
        done++;
      end else if (r < 93) begin
        report_tx(STA_W'(sta), FRM_W'($urandom_range(0, 255)), FRM_W'($urandom_range(0, 255)));
        done++;
      end else begin
        choose_rate(STA_W'(sta));
        done++;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_INIT;
    in_ch.station <= '0;
    in_ch.frames_sent <= '0;
    in_ch.retries_seen <= '0;
    in_ch.rate_count <= '0;
    in_ch.start_rate <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MIN_THR;
    cfg_ch.wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clamping on init, step up, step down with doubling, edge counts
    init_sta(0, CNT_W'(MAX_RATES), 15);
    init_sta(1, 0, 5);
    init_sta(2, 31, 3);
    init_sta(3, 4, 15);
    init_sta(15, CNT_W'(MAX_RATES), 0);
    init_sta(4, 17, 15);
    report_tx(15, 255, 0);
    choose_rate(15);
    report_tx(15, 200, 150);
    choose_rate(15);
    report_tx(15, 100, 100);
    choose_rate(15);
    report_tx(15, 10, 0);
    choose_rate(15);
    report_tx(15, 1, 0);
    choose_rate(15);
    send_req(CMD_UNUSED, 15, 8'hff, 8'hff, 5'h1f, 4'hf);
    choose_rate(0);
    report_tx(0, 255, 0);
    choose_rate(0);
    report_tx(3, 0, 255);
    choose_rate(3);
    report_tx(1, 0, 0);
    send_req(CMD_UNUSED, 2, 8'h00, 8'h00, 5'h00, 4'h0);

    set_thresholds(2, 15);
    traffic(250);
    set_thresholds(1, 1);
    traffic(200);

    // long good run to a rise at the largest threshold
    set_thresholds(255, 255);
    traffic(150);
    init_sta(9, CNT_W'(MAX_RATES), 0);
    repeat (256) begin
      report_tx(9, 200, 0);
      choose_rate(9);
    end

    // counters pinned at their ceiling
    set_thresholds(1, 255);
    traffic(200);
    init_sta(12, 8, 4);
    repeat (260) report_tx(12, 255, 255);
    choose_rate(12);

    set_thresholds(0, 8);
    traffic(150);
    set_thresholds(200, 3);
    traffic(100);
    set_thresholds(THR_W'($urandom_range(1, 255)), THR_W'($urandom_range(1, 255)));
    traffic(150);

    drain_requests();
    repeat (10) @(posedge clk);
    if (fails == 0 && due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
